[rtl/core/smbs_pkg.sv]
package smbs_pkg;

	// Fixed field widths of the item and configuration interfaces.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned CFG_W   = 6;
	localparam int unsigned CFG_IDX_W = 1;

	// A dimension in use never exceeds the largest configuration value, so a
	// linear position fits in twice the configuration width.
	localparam int unsigned POS_W = 2 * CFG_W;
	localparam int unsigned SUM_W = POS_W + 1;

	// Width used to compare a configuration value against a size parameter.
	localparam int unsigned PARAM_W = 9;

	// Default matrix capacity.
	localparam int unsigned MAX_ROWS_DEF    = 32;
	localparam int unsigned MAX_COLUMNS_DEF = 32;

	// Operation codes of an input item.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic write;
		logic init;
		logic issue;
		logic check;
		logic out_load;
	} smbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_empty;
		logic probe_hit;
	} smbs_status_t;

endpackage

[rtl/core/smbs_datapath.sv]
module smbs_datapath #(
	parameter int unsigned MAX_ROWS    = smbs_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLUMNS = smbs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smbs_pkg::smbs_cmd_t                   cmd,
	output smbs_pkg::smbs_status_t                status,
	input  logic [smbs_pkg::IDX_W-1:0]            row_index,
	input  logic [smbs_pkg::IDX_W-1:0]            column_index,
	input  logic signed [smbs_pkg::DATA_W-1:0]    data_value,
	input  logic                                  cfg_write,
	input  logic [smbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [smbs_pkg::CFG_W-1:0]            cfg_data,
	output logic                                  found
);

	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [smbs_pkg::CFG_W-1:0]         row_count_q;
	logic [smbs_pkg::CFG_W-1:0]         column_count_q;
	logic [smbs_pkg::IDX_W-1:0]         row_q;
	logic [smbs_pkg::IDX_W-1:0]         col_q;
	logic signed [smbs_pkg::DATA_W-1:0] data_q;
	logic [smbs_pkg::POS_W-1:0]         low_q;
	logic [smbs_pkg::POS_W-1:0]         hx_q;
	logic [smbs_pkg::POS_W-1:0]         mid_q;
	logic                               hit_q;
	logic                               found_q;
	logic signed [smbs_pkg::DATA_W-1:0] rdata_q;
	logic [smbs_pkg::DATA_W-1:0]        mem [DEPTH];

	logic [smbs_pkg::PARAM_W-1:0] rows_clamp;
	logic [smbs_pkg::PARAM_W-1:0] cols_clamp;
	logic [smbs_pkg::CFG_W-1:0]   rows_use;
	logic [smbs_pkg::CFG_W-1:0]   cols_use;
	logic [smbs_pkg::POS_W-1:0]   total;
	logic [smbs_pkg::POS_W-1:0]   wr_pos;
	logic                         wr_in_range;
	logic [smbs_pkg::SUM_W-1:0]   mid_sum;
	logic [smbs_pkg::POS_W-1:0]   mid;
	logic [AW+smbs_pkg::POS_W-1:0] wr_pos_ext;
	logic [AW+smbs_pkg::POS_W-1:0] mid_ext;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr;

	// Dimensions in use are the configured counts limited to the capacity.
	always_comb begin
		rows_clamp = (smbs_pkg::PARAM_W'(row_count_q) > smbs_pkg::PARAM_W'(MAX_ROWS)) ?
			smbs_pkg::PARAM_W'(MAX_ROWS) : smbs_pkg::PARAM_W'(row_count_q);
		cols_clamp = (smbs_pkg::PARAM_W'(column_count_q) > smbs_pkg::PARAM_W'(MAX_COLUMNS)) ?
			smbs_pkg::PARAM_W'(MAX_COLUMNS) : smbs_pkg::PARAM_W'(column_count_q);
		rows_use = rows_clamp[smbs_pkg::CFG_W-1:0];
		cols_use = cols_clamp[smbs_pkg::CFG_W-1:0];
		total    = rows_use * cols_use;
	end

	// Linear position of an element write and its range check.
	always_comb begin
		wr_in_range = (smbs_pkg::CFG_W'(row_q) < rows_use) &&
			(smbs_pkg::CFG_W'(col_q) < cols_use);
		wr_pos      = smbs_pkg::POS_W'(row_q) * smbs_pkg::POS_W'(cols_use) +
			smbs_pkg::POS_W'(col_q);
		wr_pos_ext  = {{AW{1'b0}}, wr_pos};
		wr_addr     = wr_pos_ext[AW-1:0];
	end

	// Midpoint of the open search window [low, hx): floor((low + hx - 1) / 2).
	always_comb begin
		mid_sum = smbs_pkg::SUM_W'(low_q) + smbs_pkg::SUM_W'(hx_q) - smbs_pkg::SUM_W'(1);
		mid     = mid_sum[smbs_pkg::SUM_W-1:1];
		mid_ext = {{AW{1'b0}}, mid};
		rd_addr = mid_ext[AW-1:0];
	end

	assign status.range_empty = (low_q >= hx_q);
	assign status.probe_hit   = (rdata_q == data_q);
	assign found              = found_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= '0;
			column_count_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == smbs_pkg::REG_ROW_COUNT) begin
				row_count_q <= cfg_data;
			end else begin
				column_count_q <= cfg_data;
			end
		end
	end

	// Item payload captured on an input transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q  <= row_index;
			col_q  <= column_index;
			data_q <= data_value;
		end
	end

	// Search window, probe position and hit flag.
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			low_q <= '0;
			hx_q  <= total;
			hit_q <= 1'b0;
		end else if (cmd.check) begin
			if (status.probe_hit) begin
				hit_q <= 1'b1;
			end else if (rdata_q < data_q) begin
				low_q <= mid_q + smbs_pkg::POS_W'(1);
			end else begin
				hx_q <= mid_q;
			end
		end
		if (cmd.issue) begin
			mid_q <= mid;
		end
		if (cmd.out_load) begin
			found_q <= hit_q;
		end
	end

	// Element store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write && wr_in_range) begin
			mem[wr_addr] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_q <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/smbs_ctrl.sv]
module smbs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	output logic                   out_valid,
	input  logic                   out_stall,
	output smbs_pkg::smbs_cmd_t    cmd,
	input  smbs_pkg::smbs_status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_INIT,
		ST_ISSUE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.write    = (state_q == ST_WRITE);
		cmd.init     = (state_q == ST_INIT);
		cmd.issue    = (state_q == ST_ISSUE) && !status.range_empty;
		cmd.check    = (state_q == ST_CHECK);
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	// State sequence and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (operation == smbs_pkg::OP_SEARCH) ? ST_INIT : ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_INIT: begin
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= status.range_empty ? ST_FINISH : ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= status.probe_hit ? ST_FINISH : ST_ISSUE;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/sorted_matrix_binary_search.sv]
// Channel   Direction  Handshake                 Payload
// input     in         in_valid / in_stall       operation, row_index, column_index, data_value
// result    out        out_valid / out_stall     found
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A write item consists of the transfer and then the store write.
// A search item consists of the transfer, the window init, the probes and the result load, with
// at most 11 probes for 32 x 32; a probe is one registered read plus a compare.
// Reset clears the dimension registers to zero; the element store is not cleared.
// The next item is taken once the result is loaded into the output register, even if
// that result is still stalled; a stalled result holds the search in its last state.
module sorted_matrix_binary_search #(
	parameter int unsigned MAX_ROWS    = smbs_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLUMNS = smbs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [smbs_pkg::IDX_W-1:0]         row_index,
	input  logic [smbs_pkg::IDX_W-1:0]         column_index,
	input  logic signed [smbs_pkg::DATA_W-1:0] data_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [smbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smbs_pkg::CFG_W-1:0]         cfg_data
);

	smbs_pkg::smbs_cmd_t    cmd;
	smbs_pkg::smbs_status_t status;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	smbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	smbs_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.row_index    (row_index),
		.column_index (column_index),
		.data_value   (data_value),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.found        (found)
	);

endmodule
